### src/assert_macros.svh
// Assertion macros shared by the stereo gain ramp RTL.
// Files that check their own logic include this header by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every rising clock edge outside reset.
`define SGR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define SGR_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define SGR_ASSERT(lbl, prop, msg)
`define SGR_NEVER(lbl, cond, msg)
`endif
`endif

### src/sgr_pkg.sv
// Package for the stereo gain ramp: widths, gain constants and shared types.
// Used by sgr_ramp, sgr_lane and stereo_gain_ramp.
`default_nettype none
package sgr_pkg;
	// Buffer length in frames; must be a power of two so the per-frame step is a shift.
	localparam int FRAMES_PER_BUFFER = 256;
	localparam int FRAME_SHIFT = $clog2(FRAMES_PER_BUFFER + 1) - 1;
	localparam int POS_W = (FRAME_SHIFT < 1) ? 1 : FRAME_SHIFT;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAMES_PER_BUFFER - 1);

	localparam int SAMPLE_W = 16;
	localparam int MAG_W = SAMPLE_W + 1;
	localparam int RAW_GAIN_W = 32;
	localparam int TARGET_W = 17;
	localparam int STEP_W = TARGET_W + 1;
	localparam int GAIN_W = TARGET_W + FRAME_SHIFT;
	localparam int PROD_W = MAG_W + GAIN_W;
	localparam int PROD_SHIFT = 16 + FRAME_SHIFT;

	localparam logic [TARGET_W-1:0] UNITY_GAIN = 17'h10000;
	localparam logic [GAIN_W-1:0] UNITY_RAMP = GAIN_W'({UNITY_GAIN, {FRAME_SHIFT{1'b0}}});

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// Per-frame control handed from the ramp controller to the lanes.
	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic              bypass;
	} frame_ctl_t;
endpackage
`default_nettype wire

### src/sgr_ramp.sv
// Ramp controller: frame counter, latched targets and the linear gain accumulator.
// Depends on sgr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sgr_ramp import sgr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire logic [RAW_GAIN_W-1:0] target_gain,
	input  wire logic                  vol_on,
	output frame_ctl_t                 ctl
);
	logic [POS_W-1:0]         pos_q;
	logic [GAIN_W-1:0]        gain_q;
	logic signed [STEP_W-1:0] step_q;
	logic [TARGET_W-1:0]      prev_q;
	logic                     first_q;
	logic                     bypass_q;

	logic                     buf_start;
	logic [TARGET_W-1:0]      target;
	logic [TARGET_W-1:0]      prev_eff;
	logic                     unity_pass;
	logic signed [STEP_W-1:0] delta;
	logic [GAIN_W-1:0]        gain_cur;
	logic signed [STEP_W-1:0] step_cur;
	logic                     bypass_cur;
	logic [GAIN_W:0]          gain_sum;

	always_comb begin
		buf_start = (pos_q == '0);
		target = (target_gain > RAW_GAIN_W'(UNITY_GAIN)) ? UNITY_GAIN
			: target_gain[TARGET_W-1:0];
		prev_eff = first_q ? target : prev_q;
		unity_pass = (target == UNITY_GAIN) && (prev_eff == UNITY_GAIN);
		delta = $signed({1'b0, target}) - $signed({1'b0, prev_eff});
		gain_cur = gain_q;
		step_cur = step_q;
		bypass_cur = bypass_q;
		if (buf_start) begin
			if (!vol_on || unity_pass) begin
				bypass_cur = 1'b1;
			end else begin
				bypass_cur = 1'b0;
				gain_cur = GAIN_W'({prev_eff, {FRAME_SHIFT{1'b0}}});
				step_cur = delta;
			end
		end
		gain_sum = {1'b0, gain_cur} + {{(GAIN_W + 1 - STEP_W){step_cur[STEP_W-1]}}, step_cur};
		ctl.gain = gain_cur;
		ctl.bypass = bypass_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			gain_q <= '0;
			step_q <= '0;
			prev_q <= '0;
			first_q <= 1'b1;
			bypass_q <= 1'b0;
		end else if (accept) begin
			pos_q <= (pos_q == LAST_POS) ? '0 : pos_q + POS_W'(1);
			bypass_q <= bypass_cur;
			step_q <= step_cur;
			if (!bypass_cur) begin
				gain_q <= gain_sum[GAIN_W-1:0];
			end
			if (buf_start && vol_on) begin
				first_q <= 1'b0;
				prev_q <= unity_pass ? prev_eff : target;
			end
		end
	end

	`SGR_NEVER(a_gain_bound, gain_q > UNITY_RAMP, "ramp gain above unity")
	`SGR_NEVER(a_prev_bound, prev_q > UNITY_GAIN, "latched target above unity")
	`SGR_ASSERT(a_first_clear, $fell(first_q) |-> $past(vol_on) && $past(pos_q) == '0,
		"first buffer flag cleared outside a ramped buffer start")
	`SGR_ASSERT(a_pos_hold, !accept |=> $stable(pos_q), "frame position moved without a word")
endmodule
`default_nettype wire

### src/sgr_lane.sv
// One scaling lane: magnitude times ramp gain, registered, then shift and sign restore.
// Depends on sgr_pkg.
`default_nettype none
module sgr_lane import sgr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              load,
	input  wire sample_t           sample,
	input  wire logic [GAIN_W-1:0] gain,
	input  wire logic              bypass,
	output sample_t                scaled
);
	logic [MAG_W-1:0]    mag;
	logic [PROD_W-1:0]   prod_s2;
	logic                neg_s2;
	logic                byp_s2;
	sample_t             raw_s2;
	logic [MAG_W-1:0]    shifted;
	logic [MAG_W-1:0]    signed_mag;

	always_comb begin
		mag = sample[SAMPLE_W-1] ? (MAG_W'(0) - {sample[SAMPLE_W-1], sample})
			: {1'b0, sample};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s2 <= PROD_W'(mag) * PROD_W'(gain);
			neg_s2 <= sample[SAMPLE_W-1];
			byp_s2 <= bypass;
			raw_s2 <= sample;
		end
	end

	always_comb begin
		shifted = MAG_W'(prod_s2 >> PROD_SHIFT);
		signed_mag = neg_s2 ? (MAG_W'(0) - shifted) : shifted;
		scaled = byp_s2 ? raw_s2 : sample_t'(signed_mag[SAMPLE_W-1:0]);
	end
endmodule
`default_nettype wire

### src/stereo_gain_ramp.sv
// Stereo gain ramp top level: handshake pipeline, two scaling lanes and output merge.
// Depends on sgr_pkg, sgr_ramp, sgr_lane and assert_macros.svh.
//
// Usage. Each input word is one stereo frame (left_sample, right_sample)
// plus a requested gain, target_gain, in unsigned Q16 where 65536 is unity.
// A word is taken at a rising edge where in_valid is high and in_stall low;
// a result word leaves at an edge where out_valid is high and out_stall low.
// Frames are grouped into buffers of FRAMES_PER_BUFFER frames. The gain is
// sampled, clamped to unity, only on the first frame of a buffer, and the
// gain then ramps linearly from the previous buffer's target to the new one.
// The software volume register (wr_en, wr_data) is sampled at buffer starts;
// while it is off, whole buffers pass through unchanged.
// Throughput is one frame per clock while the receiver does not stall; each word
// passes through the control stage, the registered 17 x 25 bit multiply in each
// lane and the merging output register before out_valid rises.
// When the receiver stalls, words stay in place and each stage holds until the
// stage after it frees up; in_stall rises only once every stage is full.
// Reset clears the pipeline, the frame counter and the ramp state, and marks
// the next ramped buffer as the first one, which starts flat at its target.
`default_nettype none
`include "assert_macros.svh"
module stereo_gain_ramp import sgr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire sample_t               left_sample,
	input  wire sample_t               right_sample,
	input  wire logic [RAW_GAIN_W-1:0] target_gain,
	input  wire logic                  wr_en,
	input  wire logic                  wr_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output sample_t                    left_out,
	output sample_t                    right_out
);
	logic       vol_on_q;
	logic       v1_q, v2_q, v3_q;
	logic       adv1, adv2, adv3;
	logic       accept;
	frame_ctl_t ctl;
	frame_ctl_t ctl_s1;
	sample_t    left_s1, right_s1;
	sample_t    left_scaled, right_scaled;
	sample_t    left_q, right_q;

	// Each stage may load when it is empty or its content moves on.
	assign adv3 = !v3_q || !out_stall;
	assign adv2 = !v2_q || adv3;
	assign adv1 = !v1_q || adv2;
	assign in_stall = !adv1;
	assign accept = in_valid && adv1;
	assign out_valid = v3_q;
	assign left_out = left_q;
	assign right_out = right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_on_q <= 1'b0;
		end else if (wr_en) begin
			vol_on_q <= wr_data;
		end
	end

	sgr_ramp u_ramp (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.target_gain (target_gain),
		.vol_on      (vol_on_q),
		.ctl         (ctl)
	);

	// Stage one: the frame together with the gain and bypass chosen for it.
	always_ff @(posedge clk) begin
		if (accept) begin
			left_s1 <= left_sample;
			right_s1 <= right_sample;
			ctl_s1 <= ctl;
		end
	end

	// Both channels share the same gain, so the lanes run in lockstep.
	sgr_lane u_lane_left (
		.clk    (clk),
		.load   (adv2 && v1_q),
		.sample (left_s1),
		.gain   (ctl_s1.gain),
		.bypass (ctl_s1.bypass),
		.scaled (left_scaled)
	);

	sgr_lane u_lane_right (
		.clk    (clk),
		.load   (adv2 && v1_q),
		.sample (right_s1),
		.gain   (ctl_s1.gain),
		.bypass (ctl_s1.bypass),
		.scaled (right_scaled)
	);

	// The merge stage gathers both lane results into the output word.
	always_ff @(posedge clk) begin
		if (adv3 && v2_q) begin
			left_q <= left_scaled;
			right_q <= right_scaled;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (adv1) begin
				v1_q <= in_valid;
			end
			if (adv2) begin
				v2_q <= v1_q;
			end
			if (adv3) begin
				v3_q <= v2_q;
			end
		end
	end

	`SGR_ASSERT(a_stall_full, in_stall |-> v1_q && v2_q && v3_q, "input stalled with a free stage")
	`SGR_ASSERT(a_word_moves, v2_q && !out_stall |=> v3_q, "stage two word lost on its way out")
	`SGR_ASSERT(a_out_hold, v3_q && out_stall |=> v3_q && $stable(left_q) && $stable(right_q),
		"stalled result word changed")
endmodule
`default_nettype wire
